>>> rtl/quadrotor_cascaded_pid_mixer_defines.svh
// assertion macros used by the checker file
`ifndef QUADROTOR_CASCADED_PID_MIXER_DEFINES_SVH
`define QUADROTOR_CASCADED_PID_MIXER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define QCPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qcpm assertion failed");

// antecedent implies consequent in the next cycle
`define QCPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qcpm assertion failed");

`endif

>>> rtl/qcpm_pkg.sv
`timescale 1ns / 1ps
package qcpm_pkg;

  localparam int GainW = 27;
  localparam int OpW   = 38;
  localparam int NLoop = 5;

  // configuration register indexes
  localparam logic [2:0] REG_INT_EN    = 3'd0;
  localparam logic [2:0] REG_DER_EN    = 3'd1;
  localparam logic [2:0] REG_CENTER    = 3'd2;
  localparam logic [2:0] REG_ANG_SCALE = 3'd3;
  localparam logic [2:0] REG_YAW_SCALE = 3'd4;
  localparam logic [2:0] REG_THR_THRES = 3'd5;

  // Q.20 gains: kp, ki, kd per loop (roll ang, roll rate, pitch ang, pitch rate, yaw rate)
  localparam logic signed [GainW-1:0] GAIN [NLoop][3] = '{
    '{27'sd1363149, 27'sd1049,  -27'sd52429},
    '{27'sd1572864, 27'sd16777, 27'sd41943040},
    '{27'sd1153434, 27'sd1049,  -27'sd52429},
    '{27'sd1572864, 27'sd16777, 27'sd41943040},
    '{27'sd5242880, 27'sd20972, 27'sd0}
  };

  // whole-unit limits: error window, integrator, output
  localparam logic [9:0] LIM [NLoop][3] = '{
    '{10'd300,  10'd200, 10'd500},
    '{10'd1000, 10'd100, 10'd200},
    '{10'd300,  10'd200, 10'd500},
    '{10'd1000, 10'd100, 10'd200},
    '{10'd500,  10'd500, 10'd500}
  };

  typedef struct packed {
    logic start;
    logic rnd;    // 1: round and drop 20 fraction bits
  } mul_req_t;

endpackage

>>> rtl/qcpm_mul.sv
`timescale 1ns / 1ps
module qcpm_mul #(
  parameter int TW = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  qcpm_pkg::mul_req_t               req,
  input  logic signed [qcpm_pkg::GainW-1:0] op_a,
  input  logic signed [qcpm_pkg::OpW-1:0]   op_b,
  output logic signed [TW-1:0]             res,
  output logic                             done
);
  import qcpm_pkg::*;

  localparam int AW = 66;
  localparam int LoW = 19;

  typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI, PH_FIN} ph_t;

  ph_t                      ph_r;
  logic signed [GainW-1:0]  a_r;
  logic signed [OpW-1:0]    b_r;
  logic                     rnd_r;
  logic signed [AW-1:0]     acc_r;
  logic signed [TW-1:0]     res_r;
  logic                     done_r;

  logic signed [GainW+LoW:0]      prod_lo;
  logic signed [GainW+OpW-LoW-1:0] prod_hi;
  logic signed [AW-1:0]           hi_sh;
  logic signed [AW-1:0]           rnd_v;
  logic signed [AW-1:0]           sel_v;

  function automatic logic signed [TW-1:0] sat_tw(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = '0;
    hi[TW-2:0] = '1;
    lo = ~hi;
    if (x > hi) sat_tw = hi[TW-1:0];
    else if (x < lo) sat_tw = lo[TW-1:0];
    else sat_tw = x[TW-1:0];
  endfunction

  // two partial products: unsigned low slice, signed high slice
  assign prod_lo = a_r * $signed({1'b0, b_r[LoW-1:0]});
  assign prod_hi = a_r * $signed(b_r[OpW-1:LoW]);
  assign hi_sh   = AW'($signed({prod_hi, {LoW{1'b0}}}));
  assign rnd_v   = (acc_r + AW'(64'sd524288)) >>> 20;
  assign sel_v   = rnd_r ? rnd_v : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        PH_IDLE: begin
          if (req.start) begin
            a_r   <= op_a;
            b_r   <= op_b;
            rnd_r <= req.rnd;
            ph_r  <= PH_LO;
          end
        end
        PH_LO: begin
          acc_r <= AW'(prod_lo);
          ph_r  <= PH_HI;
        end
        PH_HI: begin
          acc_r <= acc_r + hi_sh;
          ph_r  <= PH_FIN;
        end
        PH_FIN: begin
          res_r  <= sat_tw(sel_v);
          done_r <= 1'b1;
          ph_r   <= PH_IDLE;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

>>> rtl/quadrotor_cascaded_pid_mixer.sv
`timescale 1ns / 1ps
// the time from input transaction to result is set by the multiplies on the shared unit:
// 3 targets, then per loop p, i when the integrator runs inside its error window, d when
// enabled; plus one output step per loop
// a new transaction is taken only after the last one has left its mix step, later while a result stalls
// in_tready is high only when the sequencer is idle; a waiting result holds the mix step
// reset (rst_n low, synchronous): registers back to defaults, loop state cleared to zero
module quadrotor_cascaded_pid_mixer #(
  parameter int TERM_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // stick_roll, stick_pitch, stick_yaw, throttle_in, angle_roll, angle_pitch,
  // rate_x, rate_y, rate_z (lowest bits first)
  input  logic [127:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // motor_a, motor_b, motor_c, motor_d, mix_saturated, zero pad (lowest bits first)
  output logic [55:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);
  import qcpm_pkg::*;

  localparam int TW = TERM_WIDTH;
  // working width for sums, clamps and the mixer
  localparam int CW = (TW + 3 > 38) ? TW + 3 : 38;

  typedef enum logic [3:0] {
    S_IDLE, S_TGT, S_TGTW, S_P, S_PW, S_I, S_IW, S_D, S_DW, S_OUT, S_MIX
  } state_t;

  state_t state_r;

  // configuration
  logic        int_en_r, der_en_r;
  logic [11:0] center_r, thr_thres_r;
  logic [15:0] ang_scale_r, yaw_scale_r;

  // latched item
  logic [11:0]        sr_r, sp_r, sy_r, thr_r;
  logic signed [15:0] ar_r, ap_r, gx_r, gy_r, gz_r;
  logic               irun_r;

  // loop state
  logic signed [TW-1:0] integ_r [NLoop];
  logic signed [TW-1:0] dh_r [NLoop];
  logic signed [TW-1:0] prev_r [3];

  // sequencer working registers
  logic [2:0]           lp_r;    // loop index
  logic signed [TW-1:0] err_r;
  logic signed [OpW-1:0] dsrc_r; // d-term operand, already clamped
  logic signed [TW-1:0] p_r;
  logic signed [TW-1:0] rout_r, pout_r, yout_r;

  // result register
  logic        out_valid_r;
  logic [11:0] mot_r [4];
  logic        msat_r;

  // shared multiplier
  mul_req_t             mreq;
  logic signed [GainW-1:0] m_a;
  logic signed [OpW-1:0]   m_b;
  logic signed [TW-1:0] m_res;
  logic                 m_done;

  qcpm_mul #(.TW(TW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .op_a  (m_a),
    .op_b  (m_b),
    .res   (m_res),
    .done  (m_done)
  );

  function automatic logic signed [TW-1:0] sat_tw(input logic signed [CW-1:0] x);
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] lo;
    hi = '0;
    hi[TW-2:0] = '1;
    lo = ~hi;
    if (x > hi) sat_tw = hi[TW-1:0];
    else if (x < lo) sat_tw = lo[TW-1:0];
    else sat_tw = x[TW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] clamp_cw(input logic signed [CW-1:0] x,
                                                    input logic signed [CW-1:0] l);
    if (x > l) clamp_cw = l;
    else if (x < -l) clamp_cw = -l;
    else clamp_cw = x;
  endfunction

  // whole units to q.16
  function automatic logic signed [CW-1:0] deg(input logic [9:0] l);
    deg = '0;
    deg[25:0] = {l, 16'b0};
  endfunction

  // multiplicand clamp to +-2^36
  function automatic logic signed [OpW-1:0] mclamp(input logic signed [CW-1:0] x);
    logic signed [CW-1:0] m;
    logic signed [CW-1:0] c;
    m = '0;
    m[36] = 1'b1;
    c = clamp_cw(x, m);
    mclamp = c[OpW-1:0];
  endfunction

  // gyro of the loop group, q.16
  logic signed [15:0]   gyro_raw;
  logic signed [CW-1:0] gyro_w;
  always_comb begin
    if (lp_r < 3'd2) gyro_raw = gx_r;
    else if (lp_r < 3'd4) gyro_raw = gy_r;
    else gyro_raw = gz_r;
  end
  assign gyro_w = CW'(gyro_raw) <<< 12;

  // stick deflection for the target product, negated for yaw
  logic [11:0]        stick_sel;
  logic signed [13:0] dev;
  always_comb begin
    if (lp_r == 3'd0) stick_sel = sr_r;
    else if (lp_r == 3'd2) stick_sel = sp_r;
    else stick_sel = sy_r;
  end
  assign dev = (lp_r == 3'd4) ? ($signed({2'b0, center_r}) - $signed({2'b0, stick_sel}))
                              : ($signed({2'b0, stick_sel}) - $signed({2'b0, center_r}));

  // loop output
  logic signed [CW-1:0] out_sum;
  logic signed [TW-1:0] loop_o;
  assign out_sum = CW'(p_r) + CW'(integ_r[lp_r]) + CW'(dh_r[lp_r]);
  assign loop_o  = sat_tw(clamp_cw(out_sum, deg(LIM[lp_r][2])));

  // outer angle error
  logic signed [15:0]   ang_raw;
  logic signed [TW-1:0] ang_err;
  assign ang_raw = (lp_r == 3'd0) ? ar_r : ap_r;
  assign ang_err = sat_tw(CW'(m_res) - (CW'(ang_raw) <<< 8));

  // rate loop setup: error against gyro and difference from last tick
  logic [1:0]           rpi;
  logic signed [TW-1:0] rsrc;
  logic signed [TW-1:0] rerr;
  logic signed [CW-1:0] rdiff;
  assign rpi   = (lp_r == 3'd0) ? 2'd0 : ((lp_r == 3'd2) ? 2'd1 : 2'd2);
  assign rsrc  = (state_r == S_OUT) ? loop_o : m_res;
  assign rerr  = sat_tw(CW'(rsrc) - gyro_w);
  assign rdiff = CW'(rerr) - CW'(prev_r[rpi]);

  // integrator window and update
  logic                 in_win;
  logic signed [TW-1:0] integ_new;
  assign in_win = (CW'(err_r) < deg(LIM[lp_r][0])) && (CW'(err_r) > -deg(LIM[lp_r][0]));
  assign integ_new = sat_tw(clamp_cw(CW'(integ_r[lp_r]) + CW'(m_res), deg(LIM[lp_r][1])));

  // multiplier operand select
  always_comb begin
    mreq.start = 1'b0;
    mreq.rnd   = 1'b1;
    m_a        = GAIN[lp_r][0];
    m_b        = mclamp(CW'(err_r));
    case (state_r)
      S_TGT: begin
        mreq.start = 1'b1;
        mreq.rnd   = 1'b0;
        m_a = GainW'($signed({1'b0, (lp_r == 3'd4) ? yaw_scale_r : ang_scale_r}));
        m_b = OpW'(dev);
      end
      S_P: mreq.start = 1'b1;
      S_I: begin
        mreq.start = 1'b1;
        m_a = GAIN[lp_r][1];
      end
      S_D: begin
        mreq.start = der_en_r;
        m_a = GAIN[lp_r][2];
        m_b = dsrc_r;
      end
      default: ;
    endcase
  end

  // x mixer
  logic signed [CW-1:0] thr_w;
  logic signed [CW-1:0] mix [4];
  logic signed [CW-1:0] mv [4];
  logic [11:0]          mot_nxt [4];
  logic [3:0]           msat_v;
  assign thr_w  = CW'($signed({1'b0, thr_r, 16'b0}));
  assign mix[0] = thr_w - CW'(pout_r) + CW'(rout_r) - CW'(yout_r);
  assign mix[1] = thr_w - CW'(pout_r) - CW'(rout_r) + CW'(yout_r);
  assign mix[2] = thr_w + CW'(pout_r) + CW'(rout_r) + CW'(yout_r);
  assign mix[3] = thr_w + CW'(pout_r) - CW'(rout_r) - CW'(yout_r);
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mv[i] = (mix[i] + CW'(32'sd32768)) >>> 16;
      msat_v[i] = 1'b0;
      mot_nxt[i] = mv[i][11:0];
      if (mv[i] < 0) begin
        mot_nxt[i] = 12'd0;
        msat_v[i] = 1'b1;
      end else if (mv[i] > CW'(32'sd4095)) begin
        mot_nxt[i] = 12'd4095;
        msat_v[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lp_r        <= 3'd0;
      int_en_r    <= 1'b1;
      der_en_r    <= 1'b1;
      center_r    <= 12'd1500;
      ang_scale_r <= 16'd2621;
      yaw_scale_r <= 16'd3932;
      thr_thres_r <= 12'd1500;
      for (int i = 0; i < NLoop; i++) begin
        integ_r[i] <= '0;
        dh_r[i]    <= '0;
      end
      for (int i = 0; i < 3; i++) prev_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INT_EN:    int_en_r    <= cfg_wdata[0];
          REG_DER_EN:    der_en_r    <= cfg_wdata[0];
          REG_CENTER:    center_r    <= cfg_wdata[11:0];
          REG_ANG_SCALE: ang_scale_r <= cfg_wdata;
          REG_YAW_SCALE: yaw_scale_r <= cfg_wdata;
          REG_THR_THRES: thr_thres_r <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      // result register loads in the mix step, empties on its transaction
      if (state_r == S_MIX && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sr_r   <= in_tdata[11:0];
            sp_r   <= in_tdata[23:12];
            sy_r   <= in_tdata[35:24];
            thr_r  <= in_tdata[47:36];
            ar_r   <= in_tdata[63:48];
            ap_r   <= in_tdata[79:64];
            gx_r   <= in_tdata[95:80];
            gy_r   <= in_tdata[111:96];
            gz_r   <= in_tdata[127:112];
            irun_r <= int_en_r && (in_tdata[47:36] > thr_thres_r);
            lp_r   <= 3'd0;
            state_r <= S_TGT;
          end
        end
        S_TGT: state_r <= S_TGTW;
        S_TGTW: begin
          if (m_done) begin
            if (lp_r == 3'd4) begin
              // yaw goes straight to its rate loop
              err_r       <= rerr;
              dsrc_r      <= mclamp(rdiff);
              prev_r[rpi] <= rerr;
            end else begin
              err_r  <= ang_err;
              dsrc_r <= mclamp(gyro_w);
            end
            state_r <= S_P;
          end
        end
        S_P: state_r <= S_PW;
        S_PW: begin
          if (m_done) begin
            p_r <= m_res;
            if (!irun_r) begin
              integ_r[lp_r] <= '0;
              state_r <= S_D;
            end else if (in_win) begin
              state_r <= S_I;
            end else begin
              state_r <= S_D;
            end
          end
        end
        S_I: state_r <= S_IW;
        S_IW: begin
          if (m_done) begin
            integ_r[lp_r] <= integ_new;
            state_r <= S_D;
          end
        end
        S_D: state_r <= der_en_r ? S_DW : S_OUT;
        S_DW: begin
          if (m_done) begin
            dh_r[lp_r] <= m_res;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          case (lp_r)
            3'd0, 3'd2: begin
              // angle loop output is the rate loop target
              err_r       <= rerr;
              dsrc_r      <= mclamp(rdiff);
              prev_r[rpi] <= rerr;
              lp_r        <= lp_r + 3'd1;
              state_r     <= S_P;
            end
            3'd1: begin
              rout_r  <= loop_o;
              lp_r    <= 3'd2;
              state_r <= S_TGT;
            end
            3'd3: begin
              pout_r  <= loop_o;
              lp_r    <= 3'd4;
              state_r <= S_TGT;
            end
            default: begin
              yout_r  <= loop_o;
              state_r <= S_MIX;
            end
          endcase
        end
        S_MIX: begin
          // hold until the result register is free
          if (!out_valid_r || out_tready) begin
            for (int i = 0; i < 4; i++) mot_r[i] <= mot_nxt[i];
            msat_r      <= |msat_v;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, msat_r, mot_r[3], mot_r[2], mot_r[1], mot_r[0]};

endmodule

>>> rtl/qcpm_checker.sv
`timescale 1ns / 1ps
`include "quadrotor_cascaded_pid_mixer_defines.svh"
module qcpm_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  // one transaction in flight: busy right after an accept
  `QCPM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // stalled result stays
  `QCPM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // pad bits stay zero
  `QCPM_ASSERT_SAME(a_pad_zero, out_tvalid, out_tdata[55:49] == 7'b0)
endmodule

bind quadrotor_cascaded_pid_mixer qcpm_props u_qcpm_props (.*);
